FILE: hdl/cpcr_pkg.sv
package cpcr_pkg;

  localparam int LANES = 4;
  localparam int SQRT_SHIFT = 8;
  localparam int DEN_SHIFT = 2;

  localparam int LANE_FX = 0;
  localparam int LANE_FY = 1;
  localparam int LANE_SX = 2;
  localparam int LANE_SY = 3;

endpackage

FILE: hdl/cpcr_in_if.sv
interface cpcr_in_if #(
  parameter int POS_WIDTH = 24,
  parameter int RADIUS_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [POS_WIDTH-1:0]    first_x;
  logic signed [POS_WIDTH-1:0]    first_y;
  logic        [RADIUS_WIDTH-1:0] first_radius;
  logic signed [POS_WIDTH-1:0]    second_x;
  logic signed [POS_WIDTH-1:0]    second_y;
  logic        [RADIUS_WIDTH-1:0] second_radius;

  modport source (
    output valid, first_x, first_y, first_radius, second_x, second_y, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_radius, second_x, second_y, second_radius,
    output ready
  );
endinterface

FILE: hdl/cpcr_out_if.sv
interface cpcr_out_if #(
  parameter int POS_WIDTH = 24
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] new_first_x;
  logic signed [POS_WIDTH-1:0] new_first_y;
  logic signed [POS_WIDTH-1:0] new_second_x;
  logic signed [POS_WIDTH-1:0] new_second_y;
  logic                        overlapped;
  logic                        coincident;

  modport source (
    output valid, new_first_x, new_first_y, new_second_x, new_second_y, overlapped,
           coincident,
    input  ready
  );
  modport sink (
    input  valid, new_first_x, new_first_y, new_second_x, new_second_y, overlapped,
           coincident,
    output ready
  );
endinterface

FILE: hdl/circle_pair_collision_resolver.sv
// throughput: one pair per cycle while the output is not stalled; the square root and the four dividers are unrolled
// into one register stage per result bit, so every stage takes a new pair each cycle
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (rst_n low, synchronous) clears only the valid bits; no clearing pass
module circle_pair_collision_resolver #(
  parameter int POS_WIDTH = 24,
  parameter int RADIUS_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  cpcr_in_if.sink       in_ch,
  cpcr_out_if.source    out_ch
);
  import cpcr_pkg::*;

  localparam int P    = POS_WIDTH;
  localparam int R    = RADIUS_WIDTH;
  localparam int RSW  = R + 1;
  localparam int SQW  = 2 * RSW;
  localparam int SN   = RSW + SQRT_SHIFT / 2;
  localparam int GW   = R + SN;
  localparam int LH   = R + 2;
  localparam int HH   = GW - LH;
  localparam int NW   = RSW + GW;
  localparam int DW   = SN + RSW + DEN_SHIFT;
  localparam int QW   = R;
  localparam int CW   = (P > R) ? P + 1 : R + 1;
  localparam int EW   = CW + 1;
  localparam int LAT  = 8 + SN + QW;
  localparam int SIDE = LAT - 1;
  localparam int S_OV   = 2;
  localparam int S_ROOT = 2 + SN;
  localparam int S_DIV  = 6 + SN + QW;

  localparam logic signed [EW-1:0] PMAX = $signed({{(EW-P+1){1'b0}}, {(P-1){1'b1}}});
  localparam logic signed [EW-1:0] PMIN = $signed({{(EW-P+1){1'b1}}, {(P-1){1'b0}}});

  typedef struct packed {
    logic [P-1:0]   x1;
    logic [P-1:0]   y1;
    logic [P-1:0]   x2;
    logic [P-1:0]   y2;
    logic [R-1:0]   r1;
    logic [R-1:0]   r2;
    logic [RSW-1:0] rs;
    logic [RSW-1:0] adx;
    logic [RSW-1:0] ady;
    logic           sx;
    logic           sy;
    logic           cand;
    logic           ov;
    logic           coinc;
  } side_t;

  function automatic logic [P-1:0] push_sat(input logic [P-1:0] base,
                                            input logic [R:0]   mag,
                                            input logic         neg);
    logic signed [EW-1:0] b;
    logic signed [EW-1:0] m;
    logic signed [EW-1:0] s;
    b = EW'($signed(base));
    m = $signed(EW'(mag));
    s = neg ? b - m : b + m;
    if (s > PMAX) begin
      s = PMAX;
    end else if (s < PMIN) begin
      s = PMIN;
    end
    return s[P-1:0];
  endfunction

  logic         en;
  logic [LAT-1:0] v_r;
  side_t        side_r [SIDE];

  assign en          = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid};
    end
  end

  // stage 1: differences, radius sum, coarse range check
  logic signed [P:0] dx_w;
  logic signed [P:0] dy_w;
  logic [P:0]        adx_w;
  logic [P:0]        ady_w;
  logic [CW-1:0]     adx_e;
  logic [CW-1:0]     ady_e;
  logic [RSW-1:0]    rs_w;
  logic [CW-1:0]     rs_e;
  logic              coinc_w;
  logic              cand_w;
  side_t             side_in;

  assign dx_w    = $signed({in_ch.first_x[P-1], in_ch.first_x})
                 - $signed({in_ch.second_x[P-1], in_ch.second_x});
  assign dy_w    = $signed({in_ch.first_y[P-1], in_ch.first_y})
                 - $signed({in_ch.second_y[P-1], in_ch.second_y});
  assign adx_w   = dx_w[P] ? -dx_w : dx_w;
  assign ady_w   = dy_w[P] ? -dy_w : dy_w;
  assign adx_e   = CW'(adx_w);
  assign ady_e   = CW'(ady_w);
  assign rs_w    = {1'b0, in_ch.first_radius} + {1'b0, in_ch.second_radius};
  assign rs_e    = CW'(rs_w);
  assign coinc_w = (dx_w == '0) && (dy_w == '0);
  assign cand_w  = !coinc_w && (adx_e < rs_e) && (ady_e < rs_e);

  always_comb begin
    side_in.x1    = in_ch.first_x;
    side_in.y1    = in_ch.first_y;
    side_in.x2    = in_ch.second_x;
    side_in.y2    = in_ch.second_y;
    side_in.r1    = in_ch.first_radius;
    side_in.r2    = in_ch.second_radius;
    side_in.rs    = rs_w;
    side_in.adx   = cand_w ? adx_e[RSW-1:0] : '0;
    side_in.ady   = cand_w ? ady_e[RSW-1:0] : '0;
    side_in.sx    = dx_w[P];
    side_in.sy    = dy_w[P];
    side_in.cand  = cand_w;
    side_in.ov    = 1'b0;
    side_in.coinc = coinc_w;
  end

  // stage 2: squares
  logic [SQW-1:0] sqx_r;
  logic [SQW-1:0] sqy_r;
  logic [SQW-1:0] rs2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= side_r[0].adx * side_r[0].adx;
      sqy_r <= side_r[0].ady * side_r[0].ady;
      rs2_r <= side_r[0].rs * side_r[0].rs;
    end
  end

  // stage 3: squared distance and exact overlap test
  logic [SQW:0]   dsq_w;
  logic           lt_w;
  logic [SQW-1:0] dsq_r;
  side_t          side_ov;

  assign dsq_w = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign lt_w  = dsq_w < {1'b0, rs2_r};

  always_comb begin
    side_ov    = side_r[S_OV-1];
    side_ov.ov = side_r[S_OV-1].cand && lt_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r <= dsq_w[SQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < SIDE; k++) begin
        side_r[k] <= (k == S_OV) ? side_ov : side_r[k-1];
      end
    end
  end

  // distance in units of 1/16
  logic [SN-1:0] root_w;

  cpcr_isqrt_pipe #(.N(SN)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .din  ({dsq_r, {SQRT_SHIFT{1'b0}}}),
    .root (root_w)
  );

  // gap and distance times radius sum
  logic [SN-1:0]     gap_r;
  logic [SN+RSW-1:0] dprod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gap_r   <= {side_r[S_ROOT].rs, {(SQRT_SHIFT/2){1'b0}}} - root_w;
      dprod_r <= root_w * side_r[S_ROOT].rs;
    end
  end

  // radius shares of the gap, denominator
  logic [GW-1:0] g1_r;
  logic [GW-1:0] g2_r;
  logic [DW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r  <= side_r[S_ROOT+1].r1 * gap_r;
      g2_r  <= side_r[S_ROOT+1].r2 * gap_r;
      den_r <= {dprod_r, {DEN_SHIFT{1'b0}}};
    end
  end

  // numerators as split partial products
  logic [LANES-1:0][RSW-1:0] fa_w;
  logic [LANES-1:0][GW-1:0]  fg_w;
  logic [LANES-1:0][RSW+LH-1:0] plo_r;
  logic [LANES-1:0][RSW+HH-1:0] phi_r;
  logic [DW-1:0]             den2_r;

  assign fa_w[LANE_FX] = side_r[S_ROOT+2].adx;
  assign fa_w[LANE_FY] = side_r[S_ROOT+2].ady;
  assign fa_w[LANE_SX] = side_r[S_ROOT+2].adx;
  assign fa_w[LANE_SY] = side_r[S_ROOT+2].ady;
  assign fg_w[LANE_FX] = g2_r;
  assign fg_w[LANE_FY] = g2_r;
  assign fg_w[LANE_SX] = g1_r;
  assign fg_w[LANE_SY] = g1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        plo_r[l] <= fa_w[l] * fg_w[l][LH-1:0];
        phi_r[l] <= fa_w[l] * fg_w[l][GW-1:LH];
      end
      den2_r <= den_r;
    end
  end

  logic [LANES-1:0][NW-1:0] num_r;
  logic [DW-1:0]            den3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        num_r[l] <= NW'(plo_r[l]) + (NW'(phi_r[l]) << LH);
      end
      den3_r <= den2_r;
    end
  end

  logic [LANES-1:0][QW-1:0] quo_w;
  logic [LANES-1:0][DW-1:0] rem_w;
  logic [DW-1:0]            den_o;

  cpcr_div_pipe #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk     (clk),
    .en      (en),
    .num     (num_r),
    .den     (den3_r),
    .quo     (quo_w),
    .rem     (rem_w),
    .den_out (den_o)
  );

  // round half up, apply sign, saturate
  logic [LANES-1:0][R:0] mag_w;
  side_t                 sd;

  assign sd = side_r[S_DIV];

  for (genvar l = 0; l < LANES; l++) begin : g_rnd
    assign mag_w[l] = {1'b0, quo_w[l]}
                    + (R+1)'({rem_w[l], 1'b0} >= {1'b0, den_o});
  end

  logic [P-1:0] nfx_r;
  logic [P-1:0] nfy_r;
  logic [P-1:0] nsx_r;
  logic [P-1:0] nsy_r;
  logic         ov_r;
  logic         coinc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd.ov) begin
        nfx_r <= push_sat(sd.x1, mag_w[LANE_FX], sd.sx);
        nfy_r <= push_sat(sd.y1, mag_w[LANE_FY], sd.sy);
        nsx_r <= push_sat(sd.x2, mag_w[LANE_SX], !sd.sx);
        nsy_r <= push_sat(sd.y2, mag_w[LANE_SY], !sd.sy);
      end else begin
        nfx_r <= sd.x1;
        nfy_r <= sd.y1;
        nsx_r <= sd.x2;
        nsy_r <= sd.y2;
      end
      ov_r    <= sd.ov;
      coinc_r <= sd.coinc;
    end
  end

  assign out_ch.valid        = v_r[LAT-1];
  assign out_ch.new_first_x  = nfx_r;
  assign out_ch.new_first_y  = nfy_r;
  assign out_ch.new_second_x = nsx_r;
  assign out_ch.new_second_y = nsy_r;
  assign out_ch.overlapped   = ov_r;
  assign out_ch.coincident   = coinc_r;

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.overlapped && out_ch.coincident))
    else $error("overlapped and coincident both set");

  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: hdl/cpcr_isqrt_pipe.sv
module cpcr_isqrt_pipe #(
  parameter int N = 21
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*N-1:0]   din,
  output logic [N-1:0]     root
);
  import cpcr_pkg::*;

  logic [2*N-1:0] rad_r  [N-1];
  logic [N-1:0]   rem_r  [N-1];
  logic [N-1:0]   root_r [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [2*N-1:0] rad_i;
    logic [N-1:0]   root_i;
    logic [N-1:0]   rem_i;
    logic [N+1:0]   cur;
    logic [N+1:0]   trial;
    logic [N+1:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rad_i  = din;
      assign root_i = '0;
      assign rem_i  = '0;
    end else begin : g_next
      assign rad_i  = rad_r[i-1];
      assign root_i = root_r[i-1];
      assign rem_i  = rem_r[i-1];
    end

    assign cur   = {rem_i, rad_i[2*(N-1-i) +: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_i[N-2:0], ge};
      end
    end

    if (i < N-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[i] <= rad_i;
          rem_r[i] <= ge ? diff[N-1:0] : cur[N-1:0];
        end
      end
    end
  end

  assign root = root_r[N-1];

endmodule

FILE: hdl/cpcr_div_pipe.sv
module cpcr_div_pipe #(
  parameter int NW = 54,
  parameter int DW = 40,
  parameter int QW = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [cpcr_pkg::LANES-1:0][NW-1:0] num,
  input  logic [DW-1:0]                den,
  output logic [cpcr_pkg::LANES-1:0][QW-1:0] quo,
  output logic [cpcr_pkg::LANES-1:0][DW-1:0] rem,
  output logic [DW-1:0]                den_out
);
  import cpcr_pkg::*;

  logic [LANES-1:0][QW-1:0] low_r [QW-1];
  logic [LANES-1:0][DW-1:0] rem_r [QW];
  logic [LANES-1:0][QW-1:0] quo_r [QW];
  logic [DW-1:0]            den_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [LANES-1:0][QW-1:0] low_i;
    logic [LANES-1:0][DW-1:0] rem_i;
    logic [LANES-1:0][QW-1:0] quo_i;
    logic [DW-1:0]            den_i;
    logic [LANES-1:0][DW-1:0] rem_n;
    logic [LANES-1:0][QW-1:0] quo_n;

    if (i == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign low_i[l] = num[l][QW-1:0];
        assign rem_i[l] = DW'(num[l][NW-1:QW]);
      end
      assign quo_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign low_i = low_r[i-1];
      assign rem_i = rem_r[i-1];
      assign quo_i = quo_r[i-1];
      assign den_i = den_r[i-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] cur;
      logic [DW:0] diff;
      logic        ge;
      assign cur      = {rem_i[l], low_i[l][QW-1-i]};
      assign diff     = cur - {1'b0, den_i};
      assign ge       = cur >= {1'b0, den_i};
      assign rem_n[l] = ge ? diff[DW-1:0] : cur[DW-1:0];
      assign quo_n[l] = {quo_i[l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_n;
        quo_r[i] <= quo_n;
        den_r[i] <= den_i;
      end
    end

    if (i < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          low_r[i] <= low_i;
        end
      end
    end
  end

  assign quo     = quo_r[QW-1];
  assign rem     = rem_r[QW-1];
  assign den_out = den_r[QW-1];

endmodule
